// ===== hw/rtl/rgbmed_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgbmed_pkg
// Types, codes and sizing constants of the RGB histogram median filter.
// ---------------------------------------------------------------------------
package rgbmed_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int MAX_RADIUS     = 7;
  localparam int LEVELS         = 256;
  localparam int LVL_W          = $clog2(LEVELS);
  localparam int OFF_W          = $clog2(MAX_RADIUS + 1) + 1;
  localparam int CNT_W          = 9;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WADDR,
    S_WREAD,
    S_WFRAME,
    S_WHIST,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/rgb_histogram_median_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_histogram_median_filter
// Frame store plus per-channel histogram median over a reflected window.
// ---------------------------------------------------------------------------
// Usage:
//   Input words carry a load (pixel into the frame store, raster order) or a
//   fetch (next filtered pixel, raster order). A load gives no result. A
//   fetch gives one output word with the three channel medians, frame_last
//   and a status.
//   A valid fetch walks the window pixel by pixel (frame memory read,
//   histogram read, histogram write), then scans the 256 histogram bins,
//   clearing them as it goes. Fetches that return an error status skip the
//   walk and the scan. One item is worked on at a time.
//   After reset a clearing pass zeroes the 256 histogram bins; no input
//   word is taken during it, configuration writes are.
//   A finished result sits in the output register; while the receiver stalls
//   loads are still taken, and a fetch waits at its end for the register.
//   Any register write restarts loading and output position.
// ---------------------------------------------------------------------------
module rgb_histogram_median_filter
  import rgbmed_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LP_W    = ADDR_W + 1;
  localparam int CMP_W   = (LP_W > 18) ? LP_W : 18;
  localparam int DIM_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int COORD_W = ((DIM_W > 9) ? DIM_W : 9) + 2;
  localparam int SUM_W   = ADDR_W + 9;

  state_t state, state_next;

  logic [2:0]       radius;
  logic [8:0]       frame_width;
  logic [8:0]       frame_height;
  logic [LP_W-1:0]  load_pos;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  logic signed [OFF_W-1:0] dx, dy;
  logic [LVL_W:0]          k;
  logic [ADDR_W-1:0]       rd_addr;
  logic [23:0]             frame_q;
  logic [7:0]              bin_q   [3];
  logic [7:0]              hq      [3];
  logic [CNT_W-1:0]        run     [3];
  logic [7:0]              med     [3];
  logic [2:0]              found;
  logic [7:0]              half;
  logic [1:0]              res_status;

  logic [7:0]  hist_mem0 [LEVELS];
  logic [7:0]  hist_mem1 [LEVELS];
  logic [7:0]  hist_mem2 [LEVELS];
  logic [23:0] frame_mem_hi [DEPTH];

  // Control decode
  logic              size_ok, loaded, in_acc, cfg_acc, out_free, is_last;
  logic [CMP_W-1:0]  total;
  logic signed [OFF_W-1:0] r_s;

  assign r_s      = $signed({1'b0, radius});
  assign size_ok  = (frame_width != 9'd0) && (32'(frame_width) <= MAX_WIDTH) &&
                    (frame_height != 9'd0) && (32'(frame_height) <= MAX_HEIGHT) &&
                    (frame_width >= 9'(radius) + 9'd1) &&
                    (frame_height >= 9'(radius) + 9'd1);
  assign total    = CMP_W'(frame_width) * CMP_W'(frame_height);
  assign loaded   = CMP_W'(load_pos) >= total;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid || !out_stall;
  assign is_last  = (32'(out_col) + 1 >= 32'(frame_width)) &&
                    (32'(out_row) + 1 >= 32'(frame_height));

  // Reflect window coordinates and form the frame address
  logic signed [COORD_W-1:0] xc, yc, xs, ys, xm, ym;
  logic [SUM_W-1:0]          addr_sum;

  always_comb begin
    xs = $signed(COORD_W'(frame_width));
    ys = $signed(COORD_W'(frame_height));
    xc = $signed(COORD_W'(out_col)) + COORD_W'(dx);
    yc = $signed(COORD_W'(out_row)) + COORD_W'(dy);
    if (xc < 0) begin
      xm = -xc;
    end else if (xc >= xs) begin
      xm = xs + xs - COORD_W'(1) - xc;
    end else begin
      xm = xc;
    end
    if (yc < 0) begin
      ym = -yc;
    end else if (yc >= ys) begin
      ym = ys + ys - COORD_W'(1) - yc;
    end else begin
      ym = yc;
    end
    addr_sum = SUM_W'(ym[ROW_W-1:0]) * SUM_W'(frame_width) + SUM_W'(xm[COL_W-1:0]);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (k == (LVL_W+1)'(LEVELS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_acc && in_word.req_type == REQ_FETCH) begin
          state_next = (size_ok && loaded) ? S_WADDR : S_DONE;
        end
      end
      S_WADDR:  state_next = S_WREAD;
      S_WREAD:  state_next = S_WFRAME;
      S_WFRAME: state_next = S_WHIST;
      S_WHIST:  state_next = (dx == r_s && dy == r_s) ? S_SCAN : S_WADDR;
      S_SCAN:   if (k == (LVL_W+1)'(LEVELS)) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Histogram memory controls
  logic             hist_we;
  logic [LVL_W-1:0] hist_waddr [3];
  logic [7:0]       hist_wdata [3];
  logic [LVL_W-1:0] hist_raddr [3];

  always_comb begin
    hist_we = 1'b0;
    for (int c = 0; c < 3; c++) begin
      hist_waddr[c] = k[LVL_W-1:0];
      hist_wdata[c] = 8'd0;
      hist_raddr[c] = k[LVL_W-1:0];
    end
    case (state)
      S_CLEAR: hist_we = 1'b1;
      S_WFRAME: begin
        for (int c = 0; c < 3; c++) hist_raddr[c] = frame_q[8*c +: 8];
      end
      S_WHIST: begin
        hist_we = 1'b1;
        for (int c = 0; c < 3; c++) begin
          hist_waddr[c] = bin_q[c];
          hist_wdata[c] = hq[c] + 8'd1;
        end
      end
      S_SCAN: begin
        hist_we = (k != '0);
        for (int c = 0; c < 3; c++) hist_waddr[c] = LVL_W'(k - 1'b1);
      end
      default: hist_we = 1'b0;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (in_acc && in_word.req_type == REQ_LOAD && size_ok) begin
      frame_mem_hi[loaded ? '0 : load_pos[ADDR_W-1:0]] <=
        {in_word.in_blue, in_word.in_green, in_word.in_red};
    end
    frame_q <= frame_mem_hi[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem0[hist_waddr[0]] <= hist_wdata[0];
      hist_mem1[hist_waddr[1]] <= hist_wdata[1];
      hist_mem2[hist_waddr[2]] <= hist_wdata[2];
    end
    hq[0] <= hist_mem0[hist_raddr[0]];
    hq[1] <= hist_mem1[hist_raddr[1]];
    hq[2] <= hist_mem2[hist_raddr[2]];
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      radius       <= 3'd1;
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      load_pos     <= '0;
      out_col      <= '0;
      out_row      <= '0;
      k            <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // Raise the result word when done, drop it once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_acc && cfg_index <= REG_HEIGHT) begin
        case (cfg_index)
          REG_RADIUS: radius       <= cfg_data[2:0];
          REG_WIDTH:  frame_width  <= cfg_data;
          REG_HEIGHT: frame_height <= cfg_data;
          default:    radius       <= radius;
        endcase
        load_pos <= '0;
        out_col  <= '0;
        out_row  <= '0;
      end
      case (state)
        S_CLEAR: k <= k + 1'b1;
        S_IDLE: begin
          k <= '0;
          if (in_acc && in_word.req_type == REQ_LOAD && size_ok) begin
            if (loaded) begin
              load_pos <= LP_W'(1);
              out_col  <= '0;
              out_row  <= '0;
            end else begin
              load_pos <= load_pos + 1'b1;
            end
          end
        end
        S_SCAN: k <= k + 1'b1;
        S_DONE: begin
          if (out_free) begin
            if (res_status == ST_OK) begin
              if (is_last) begin
                out_col <= '0;
                out_row <= '0;
              end else if (32'(out_col) + 1 >= 32'(frame_width)) begin
                out_col <= '0;
                out_row <= out_row + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
          end
        end
        default: k <= k;
      endcase
    end
  end

  // Window walk, scan and result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dx    <= -r_s;
        dy    <= -r_s;
        found <= 3'b000;
        half  <= 8'((({5'd0, radius} * 8'd2 + 8'd1) *
                     ({5'd0, radius} * 8'd2 + 8'd1)) >> 1);
        for (int c = 0; c < 3; c++) begin
          run[c] <= '0;
          med[c] <= 8'd255;
        end
        if (!size_ok) res_status <= ST_BAD_SIZE;
        else if (!loaded) res_status <= ST_NOT_LOADED;
        else res_status <= ST_OK;
      end
      S_WADDR: rd_addr <= ADDR_W'(addr_sum);
      S_WFRAME: begin
        for (int c = 0; c < 3; c++) bin_q[c] <= frame_q[8*c +: 8];
      end
      S_WHIST: begin
        if (dx == r_s) begin
          dx <= -r_s;
          dy <= dy + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
      S_SCAN: begin
        if (k != '0) begin
          for (int c = 0; c < 3; c++) begin
            run[c] <= run[c] + CNT_W'(hq[c]);
            if (!found[c] && (run[c] + CNT_W'(hq[c]) > CNT_W'(half))) begin
              found[c] <= 1'b1;
              med[c]   <= LVL_W'(k - 1'b1);
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (res_status == ST_OK) begin
            out_word.out_red    <= med[0];
            out_word.out_green  <= med[1];
            out_word.out_blue   <= med[2];
            out_word.frame_last <= is_last;
          end else begin
            out_word.out_red    <= 8'd0;
            out_word.out_green  <= 8'd0;
            out_word.out_blue   <= 8'd0;
            out_word.frame_last <= 1'b0;
          end
          out_word.status <= res_status;
        end
      end
      default: rd_addr <= rd_addr;
    endcase
  end

endmodule
